// ----- sv/bfp_pkg.sv -----
// Shared constants, types and state codes of the free block pool.
package bfp_pkg;

   localparam int POOL_SLOTS  = 64;
   localparam int HANDLE_BITS = 48;
   localparam int SIZE_W      = 32;
   localparam int TOTAL_W     = 37;
   localparam int IDX_W       = $clog2(POOL_SLOTS);
   localparam int CNT_W       = $clog2(POOL_SLOTS + 1);
   localparam int ENTRY_W     = SIZE_W + HANDLE_BITS;

   localparam logic [SIZE_W-1:0]  MIN_BLOCK   = SIZE_W'(256);
   localparam logic [SIZE_W:0]    MAX_BLOCK   = (SIZE_W + 1)'(64'd4 * 64'd1073741824);
   localparam logic [TOTAL_W-1:0] LIMIT_RESET = TOTAL_W'(64'd16 * 64'd1073741824);

   localparam logic KIND_RELEASE = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_REL_SCAN,
      ST_REQ_SCAN,
      ST_REQ_DRAIN,
      ST_REQ_FETCH,
      ST_REQ_GRANT,
      ST_DONE
   } bfp_state_type;

   typedef struct packed {
      logic load;
      logic rel_step;
      logic rel_commit;
      logic req_issue;
      logic fetch;
      logic req_commit;
      logic fail;
      logic out_load;
   } bfp_cmd_type;

   typedef struct packed {
      logic kind;
      logic in_window;
      logic limit_ok;
      logic slot_free;
      logic scan_last;
      logic best_found;
      logic fit_ok;
      logic out_free;
   } bfp_stat_type;

endpackage

// ----- sv/bfp_req_if.sv -----
// Request channel: one release or request item per handshake.
interface bfp_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic [bfp_pkg::SIZE_W-1:0]          block_size;
   logic [bfp_pkg::HANDLE_BITS-1:0]     block_handle;

   modport source (output valid, kind, block_size, block_handle, input ready);
   modport sink   (input valid, kind, block_size, block_handle, output ready);
endinterface

// ----- sv/bfp_rsp_if.sv -----
// Response channel: one result item per accepted request item.
interface bfp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                success;
   logic [bfp_pkg::HANDLE_BITS-1:0]     granted_handle;
   logic [bfp_pkg::SIZE_W-1:0]          granted_size;
   logic [bfp_pkg::TOTAL_W-1:0]         pooled_total;

   modport source (output valid, success, granted_handle, granted_size, pooled_total,
                   input ready);
   modport sink   (input valid, success, granted_handle, granted_size, pooled_total,
                   output ready);
endinterface

// ----- sv/bfp_ctrl.sv -----
// Controller state machine: sequences release and best-fit request scans.
module bfp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bfp_pkg::bfp_stat_type  stat,
   output bfp_pkg::bfp_cmd_type   cmd
);

   bfp_pkg::bfp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfp_pkg::ST_IDLE: begin
            if (req_valid) state_in = bfp_pkg::ST_EVAL;
         end
         bfp_pkg::ST_EVAL: begin
            if (!stat.in_window) begin
               state_in = bfp_pkg::ST_DONE;
            end else if (stat.kind == bfp_pkg::KIND_REQUEST) begin
               state_in = bfp_pkg::ST_REQ_SCAN;
            end else if (stat.limit_ok) begin
               state_in = bfp_pkg::ST_REL_SCAN;
            end else begin
               state_in = bfp_pkg::ST_DONE;
            end
         end
         bfp_pkg::ST_REL_SCAN: begin
            if (stat.slot_free || stat.scan_last) state_in = bfp_pkg::ST_DONE;
         end
         bfp_pkg::ST_REQ_SCAN: begin
            if (stat.scan_last) state_in = bfp_pkg::ST_REQ_DRAIN;
         end
         bfp_pkg::ST_REQ_DRAIN: begin
            state_in = bfp_pkg::ST_REQ_FETCH;
         end
         bfp_pkg::ST_REQ_FETCH: begin
            if (stat.best_found && stat.fit_ok) begin
               state_in = bfp_pkg::ST_REQ_GRANT;
            end else begin
               state_in = bfp_pkg::ST_DONE;
            end
         end
         bfp_pkg::ST_REQ_GRANT: begin
            state_in = bfp_pkg::ST_DONE;
         end
         bfp_pkg::ST_DONE: begin
            if (stat.out_free) state_in = bfp_pkg::ST_IDLE;
         end
         default: begin
            state_in = bfp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         bfp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         bfp_pkg::ST_EVAL: begin
            cmd.fail = !stat.in_window ||
                       (stat.kind == bfp_pkg::KIND_RELEASE && !stat.limit_ok);
         end
         bfp_pkg::ST_REL_SCAN: begin
            cmd.rel_commit = stat.slot_free;
            cmd.fail       = !stat.slot_free && stat.scan_last;
            cmd.rel_step   = !stat.slot_free && !stat.scan_last;
         end
         bfp_pkg::ST_REQ_SCAN: begin
            cmd.req_issue = 1'b1;
         end
         bfp_pkg::ST_REQ_FETCH: begin
            cmd.fetch = stat.best_found && stat.fit_ok;
            cmd.fail  = !(stat.best_found && stat.fit_ok);
         end
         bfp_pkg::ST_REQ_GRANT: begin
            cmd.req_commit = 1'b1;
         end
         bfp_pkg::ST_DONE: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- sv/bfp_dpath.sv -----
// Datapath: slot table, valid bits, running total, best-fit tracker and result register.
module bfp_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  bfp_pkg::bfp_cmd_type              cmd,
   output bfp_pkg::bfp_stat_type             stat,
   input  logic                              req_kind,
   input  logic [bfp_pkg::SIZE_W-1:0]        req_block_size,
   input  logic [bfp_pkg::HANDLE_BITS-1:0]   req_block_handle,
   input  logic                              csr_wr_en,
   input  logic [bfp_pkg::TOTAL_W-1:0]       csr_wr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_success,
   output logic [bfp_pkg::HANDLE_BITS-1:0]   rsp_granted_handle,
   output logic [bfp_pkg::SIZE_W-1:0]        rsp_granted_size,
   output logic [bfp_pkg::TOTAL_W-1:0]       rsp_pooled_total
);

   logic                              kind_ff;
   logic [bfp_pkg::SIZE_W-1:0]        size_ff;
   logic [bfp_pkg::HANDLE_BITS-1:0]   handle_ff;
   logic [bfp_pkg::TOTAL_W-1:0]       limit_ff;
   logic [bfp_pkg::TOTAL_W-1:0]       total_ff, total_in;
   logic [bfp_pkg::POOL_SLOTS-1:0]    valid_ff;
   logic [bfp_pkg::CNT_W-1:0]         cnt_ff;
   logic [bfp_pkg::IDX_W-1:0]         cnt_idx;

   logic [bfp_pkg::ENTRY_W-1:0]       slot_mem [bfp_pkg::POOL_SLOTS];
   logic [bfp_pkg::ENTRY_W-1:0]       rd_ff;
   logic                              mem_re;
   logic [bfp_pkg::IDX_W-1:0]         mem_raddr;
   logic [bfp_pkg::SIZE_W-1:0]        rd_size;
   logic [bfp_pkg::HANDLE_BITS-1:0]   rd_handle;

   logic                              cmp_ff;
   logic                              rd_vld_ff;
   logic [bfp_pkg::IDX_W-1:0]         rd_idx_ff;
   logic                              best_found_ff;
   logic [bfp_pkg::IDX_W-1:0]         best_idx_ff;
   logic [bfp_pkg::SIZE_W-1:0]        best_size_ff;
   logic                              better;

   logic                              res_ok_ff;
   logic [bfp_pkg::HANDLE_BITS-1:0]   res_handle_ff;
   logic [bfp_pkg::SIZE_W-1:0]        res_size_ff;
   logic                              rsp_valid_ff;
   logic [bfp_pkg::TOTAL_W:0]         rel_sum;

   assign cnt_idx   = cnt_ff[bfp_pkg::IDX_W-1:0];
   assign rd_size   = rd_ff[bfp_pkg::ENTRY_W-1 -: bfp_pkg::SIZE_W];
   assign rd_handle = rd_ff[bfp_pkg::HANDLE_BITS-1:0];
   assign rel_sum   = {1'b0, total_ff} + (bfp_pkg::TOTAL_W + 1)'(size_ff);

   assign mem_re    = cmd.req_issue || cmd.fetch;
   assign mem_raddr = cmd.fetch ? best_idx_ff : cnt_idx;

   assign better = cmp_ff && rd_vld_ff && (rd_size >= size_ff) &&
                   (!best_found_ff || rd_size < best_size_ff);

   always_comb begin
      stat.kind       = kind_ff;
      stat.in_window  = (size_ff > bfp_pkg::MIN_BLOCK) &&
                        ({1'b0, size_ff} < bfp_pkg::MAX_BLOCK);
      stat.limit_ok   = rel_sum < {1'b0, limit_ff};
      stat.slot_free  = !valid_ff[cnt_idx];
      stat.scan_last  = cnt_ff == bfp_pkg::CNT_W'(bfp_pkg::POOL_SLOTS - 1);
      stat.best_found = best_found_ff;
      stat.fit_ok     = {1'b0, best_size_ff} < {size_ff, 1'b0};
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.rel_commit) begin
         total_in = total_ff + bfp_pkg::TOTAL_W'(size_ff);
      end else if (cmd.req_commit) begin
         total_in = total_ff - bfp_pkg::TOTAL_W'(best_size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rel_commit) slot_mem[cnt_idx] <= {size_ff, handle_ff};
      if (mem_re) rd_ff <= slot_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= bfp_pkg::LIMIT_RESET;
         total_ff      <= '0;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         cmp_ff        <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) limit_ff <= csr_wr_data;
         total_ff <= total_in;
         cmp_ff   <= cmd.req_issue;
         if (cmd.load) begin
            cnt_ff        <= '0;
            best_found_ff <= 1'b0;
         end else if (cmd.rel_step || cmd.req_issue) begin
            cnt_ff <= cnt_ff + bfp_pkg::CNT_W'(1);
         end
         if (better) best_found_ff <= 1'b1;
         if (cmd.rel_commit) valid_ff[cnt_idx] <= 1'b1;
         if (cmd.req_commit) valid_ff[best_idx_ff] <= 1'b0;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         size_ff   <= req_block_size;
         handle_ff <= req_block_handle;
      end
      if (cmd.req_issue) begin
         rd_vld_ff <= valid_ff[cnt_idx];
         rd_idx_ff <= cnt_idx;
      end
      if (better) begin
         best_idx_ff  <= rd_idx_ff;
         best_size_ff <= rd_size;
      end
      if (cmd.fail) begin
         res_ok_ff     <= 1'b0;
         res_handle_ff <= '0;
         res_size_ff   <= size_ff;
      end else if (cmd.rel_commit) begin
         res_ok_ff     <= 1'b1;
         res_handle_ff <= '0;
         res_size_ff   <= size_ff;
      end else if (cmd.req_commit) begin
         res_ok_ff     <= 1'b1;
         res_handle_ff <= rd_handle;
         res_size_ff   <= best_size_ff;
      end
      if (cmd.out_load) begin
         rsp_success        <= res_ok_ff;
         rsp_granted_handle <= res_handle_ff;
         rsp_granted_size   <= res_size_ff;
         rsp_pooled_total   <= total_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rel_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rel_commit |=> valid_ff[$past(cnt_idx)])
      else $error("released slot not marked valid");

   a_grant_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.req_commit |-> (best_found_ff && stat.fit_ok))
      else $error("grant without a fitting block");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_grant_lowers_total: assert property (@(posedge clock) disable iff (reset)
      cmd.req_commit |=> (total_ff == $past(total_ff) - bfp_pkg::TOTAL_W'($past(best_size_ff))))
      else $error("pool total not reduced by granted size");

endmodule

// ----- sv/best_fit_free_block_pool_core.sv -----
// Top level of the best-fit free block pool.
//
//  channel   dir   handshake             payload
//  req_if    in    valid/ready           kind, block_size, block_handle
//  rsp_if    out   valid/ready           success, granted_handle, granted_size, pooled_total
//  csr_*     in    csr_wr_en             csr_wr_data = pool limit in bytes
//
// A request item runs evaluate, reads of all 64 slots through the single table read port, then
// drain, fetch, grant (skipped on a miss) and result load. A release walks the valid bits to the
// lowest free slot; a rejected item goes from evaluate straight to the result load.
// One item is in work at a time; the result register holds until rsp_if.ready.
// Synchronous reset empties the pool and sets the limit to 16 GiB.
module best_fit_free_block_pool_core (
   input  logic                              clock,
   input  logic                              reset,
   bfp_req_if.sink                           req_if,
   bfp_rsp_if.source                         rsp_if,
   input  logic                              csr_wr_en,
   input  logic [bfp_pkg::TOTAL_W-1:0]       csr_wr_data
);

   bfp_pkg::bfp_cmd_type  cmd;
   bfp_pkg::bfp_stat_type stat;

   bfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bfp_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_kind           (req_if.kind),
      .req_block_size     (req_if.block_size),
      .req_block_handle   (req_if.block_handle),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_success        (rsp_if.success),
      .rsp_granted_handle (rsp_if.granted_handle),
      .rsp_granted_size   (rsp_if.granted_size),
      .rsp_pooled_total   (rsp_if.pooled_total)
   );

endmodule

// ----- test/best_fit_free_block_pool_core_test.sv -----
// Self-checking testbench of the best-fit free block pool: directed table, then random items.
module best_fit_free_block_pool_core_test;

   localparam logic [bfp_pkg::TOTAL_W-1:0] BIG_LIMIT   = bfp_pkg::TOTAL_W'(64'd1 << 36);
   localparam int                          STALL_LIMIT = 3000;
   localparam int                          SEGMENTS    = 12;
   localparam int                          SEG_ITEMS   = 140;

   typedef struct packed {
      logic                            success;
      logic [bfp_pkg::HANDLE_BITS-1:0] granted_handle;
      logic [bfp_pkg::SIZE_W-1:0]      granted_size;
      logic [bfp_pkg::TOTAL_W-1:0]     pooled_total;
   } pool_outcome_type;

   typedef struct {
      bit                              is_limit;
      logic [bfp_pkg::TOTAL_W-1:0]     limit;
      logic                            kind;
      logic [bfp_pkg::SIZE_W-1:0]      block_size;
      logic [bfp_pkg::HANDLE_BITS-1:0] block_handle;
      bit                              typed;
      pool_outcome_type                outcome;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_wr_en;
   logic [bfp_pkg::TOTAL_W-1:0]  csr_wr_data;

   bfp_req_if req_ch ();
   bfp_rsp_if rsp_ch ();

   best_fit_free_block_pool_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bit                              slot_used [bfp_pkg::POOL_SLOTS];
   logic [bfp_pkg::SIZE_W-1:0]      slot_bytes [bfp_pkg::POOL_SLOTS];
   logic [bfp_pkg::HANDLE_BITS-1:0] slot_addr [bfp_pkg::POOL_SLOTS];
   logic [bfp_pkg::TOTAL_W-1:0]     pool_sum   = '0;
   logic [bfp_pkg::TOTAL_W-1:0]     pool_limit = bfp_pkg::LIMIT_RESET;

   pool_outcome_type pending_outcomes [$];
   int               mismatches = 0;
   int               idle_cycles = 0;
   int               send_idle_pct = 11;
   int               recv_idle_pct = 69;

   always #1 clock = ~clock;

   function automatic pool_outcome_type apply_pool_item(logic kind,
                                                        logic [bfp_pkg::SIZE_W-1:0] size,
                                                        logic [bfp_pkg::HANDLE_BITS-1:0] handle);
      pool_outcome_type res;
      int               best;
      int               i;
      logic             in_win;
      res = '{success: 1'b0, granted_handle: '0, granted_size: size, pooled_total: '0};
      in_win = (size > bfp_pkg::MIN_BLOCK) && ({1'b0, size} < bfp_pkg::MAX_BLOCK);
      best = -1;
      if (kind == bfp_pkg::KIND_RELEASE) begin
         if (in_win && ({1'b0, pool_sum} + (bfp_pkg::TOTAL_W + 1)'(size) <
                        {1'b0, pool_limit})) begin
            for (i = 0; i < bfp_pkg::POOL_SLOTS && best < 0; i++) begin
               if (!slot_used[i]) best = i;
            end
            if (best >= 0) begin
               slot_used[best]  = 1'b1;
               slot_bytes[best] = size;
               slot_addr[best]  = handle;
               pool_sum         = pool_sum + bfp_pkg::TOTAL_W'(size);
               res.success      = 1'b1;
            end
         end
      end else if (in_win) begin
         for (i = 0; i < bfp_pkg::POOL_SLOTS; i++) begin
            if (slot_used[i] && slot_bytes[i] >= size &&
                (best < 0 || slot_bytes[i] < slot_bytes[best])) best = i;
         end
         if (best >= 0 && {1'b0, slot_bytes[best]} < {size, 1'b0}) begin
            res.success        = 1'b1;
            res.granted_handle = slot_addr[best];
            res.granted_size   = slot_bytes[best];
            slot_used[best]    = 1'b0;
            pool_sum           = pool_sum - bfp_pkg::TOTAL_W'(slot_bytes[best]);
         end
      end
      res.pooled_total = pool_sum;
      return res;
   endfunction

   function automatic stim_row_type item_row(logic kind, logic [bfp_pkg::SIZE_W-1:0] size,
                                             logic [bfp_pkg::HANDLE_BITS-1:0] handle);
      stim_row_type row;
      row = '{is_limit: 1'b0, limit: '0, kind: kind, block_size: size, block_handle: handle,
              typed: 1'b0, outcome: '0};
      return row;
   endfunction

   function automatic stim_row_type typed_row(logic kind, logic [bfp_pkg::SIZE_W-1:0] size,
                                              logic [bfp_pkg::HANDLE_BITS-1:0] handle,
                                              logic ok,
                                              logic [bfp_pkg::HANDLE_BITS-1:0] g_handle,
                                              logic [bfp_pkg::SIZE_W-1:0] g_size,
                                              logic [bfp_pkg::TOTAL_W-1:0] total);
      stim_row_type row;
      row = item_row(kind, size, handle);
      row.typed   = 1'b1;
      row.outcome = '{success: ok, granted_handle: g_handle, granted_size: g_size,
                      pooled_total: total};
      return row;
   endfunction

   function automatic stim_row_type limit_row(logic [bfp_pkg::TOTAL_W-1:0] value);
      stim_row_type row;
      row = item_row(bfp_pkg::KIND_RELEASE, '0, '0);
      row.is_limit = 1'b1;
      row.limit    = value;
      return row;
   endfunction

   function automatic logic [bfp_pkg::SIZE_W-1:0] edge_size();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return bfp_pkg::SIZE_W'(255);
         2:       return bfp_pkg::SIZE_W'(256);
         3:       return bfp_pkg::SIZE_W'(257);
         4:       return 32'hFFFF_FFFE;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   task automatic send_item(logic kind, logic [bfp_pkg::SIZE_W-1:0] size,
                            logic [bfp_pkg::HANDLE_BITS-1:0] handle, bit typed,
                            pool_outcome_type typed_outcome);
      pool_outcome_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid        = 1'b1;
      req_ch.kind         = kind;
      req_ch.block_size   = size;
      req_ch.block_handle = handle;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_pool_item(kind, size, handle);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
   endtask

   task automatic write_limit(logic [bfp_pkg::TOTAL_W-1:0] value);
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      pool_limit  = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic pick_item(int n, output logic kind, output logic [bfp_pkg::SIZE_W-1:0] size,
                            output logic [bfp_pkg::HANDLE_BITS-1:0] handle);
      int                          r;
      int                          k;
      int                          s;
      int                          i;
      logic [bfp_pkg::TOTAL_W:0]   gap;
      logic [bfp_pkg::SIZE_W-1:0]  base;
      r    = $urandom_range(0, 99);
      kind = (r < (((n / 40) % 2 == 0) ? 70 : 30)) ? bfp_pkg::KIND_RELEASE
                                                    : bfp_pkg::KIND_REQUEST;
      r    = $urandom_range(0, 99);
      base = '0;
      if (kind == bfp_pkg::KIND_RELEASE) begin
         gap = {1'b0, pool_limit} - {1'b0, pool_sum};
         if (r < 55) size = $urandom_range(257, 8192);
         else if (r < 70) size = $urandom_range(257, 1 << 24);
         else if (r < 80 && gap != '0 && gap[bfp_pkg::TOTAL_W:bfp_pkg::SIZE_W] == '0)
            size = gap[bfp_pkg::SIZE_W-1:0] - bfp_pkg::SIZE_W'($urandom_range(0, 1));
         else if (r < 88) size = edge_size();
         else size = $urandom;
      end else begin
         k = 0;
         for (i = 0; i < bfp_pkg::POOL_SLOTS; i++) k += slot_used[i];
         if (r < 55 && k > 0) begin
            s = $urandom_range(0, k - 1);
            for (i = 0; i < bfp_pkg::POOL_SLOTS; i++) begin
               if (slot_used[i]) begin
                  if (s == 0) base = slot_bytes[i];
                  s--;
               end
            end
            case ($urandom_range(0, 3))
               0:       size = base;
               1:       size = base - bfp_pkg::SIZE_W'($urandom_range(0, base / 2));
               2:       size = base >> 1;
               default: size = (base >> 1) + 1'b1;
            endcase
         end else if (r < 80) size = $urandom_range(257, 8192);
         else if (r < 90) size = edge_size();
         else size = $urandom;
      end
      r = $urandom_range(0, 99);
      if (r < 8) handle = '0;
      else if (r < 16) handle = '1;
      else handle = bfp_pkg::HANDLE_BITS'({$urandom, $urandom});
   endtask

   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      pool_outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: success %0b handle %0h size %0h total %0h",
                        rsp_ch.success, rsp_ch.granted_handle, rsp_ch.granted_size,
                        rsp_ch.pooled_total);
         end else begin
            want = pending_outcomes.pop_front();
            check_field("success", 64'(want.success), 64'(rsp_ch.success));
            check_field("granted_handle", 64'(want.granted_handle), 64'(rsp_ch.granted_handle));
            check_field("granted_size", 64'(want.granted_size), 64'(rsp_ch.granted_size));
            check_field("pooled_total", 64'(want.pooled_total), 64'(rsp_ch.pooled_total));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("best_fit_free_block_pool_core_test: FAIL");
         $finish;
      end
   end

   initial begin
      stim_row_type                    plan [$];
      logic                            kind;
      logic [bfp_pkg::SIZE_W-1:0]      size;
      logic [bfp_pkg::HANDLE_BITS-1:0] handle;
      logic [bfp_pkg::TOTAL_W-1:0]     lim;
      int                              seg;
      int                              n;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_ch.valid        = 1'b0;
      req_ch.kind         = bfp_pkg::KIND_RELEASE;
      req_ch.block_size   = '0;
      req_ch.block_handle = '0;
      rsp_ch.ready        = 1'b0;

      plan.push_back(typed_row(bfp_pkg::KIND_REQUEST, 32'd1000, 48'h0000_1234_5678,
                               1'b0, '0, 32'd1000, '0));
      plan.push_back(typed_row(bfp_pkg::KIND_RELEASE, 32'd256, '1, 1'b0, '0, 32'd256, '0));
      plan.push_back(typed_row(bfp_pkg::KIND_RELEASE, 32'd0, '1, 1'b0, '0, 32'd0, '0));
      plan.push_back(typed_row(bfp_pkg::KIND_RELEASE, 32'd257, '0, 1'b1, '0, 32'd257,
                               37'd257));
      plan.push_back(item_row(bfp_pkg::KIND_RELEASE, 32'hFFFF_FFFF, '1));
      plan.push_back(item_row(bfp_pkg::KIND_REQUEST, 32'd257, 48'h0000_0000_ABCD));
      plan.push_back(item_row(bfp_pkg::KIND_RELEASE, 32'd1000, 48'h1111_1111_1111));
      plan.push_back(item_row(bfp_pkg::KIND_RELEASE, 32'd600, 48'h2222_2222_2222));
      plan.push_back(item_row(bfp_pkg::KIND_RELEASE, 32'd600, 48'h3333_3333_3333));
      plan.push_back(item_row(bfp_pkg::KIND_REQUEST, 32'd500, '0));
      plan.push_back(item_row(bfp_pkg::KIND_REQUEST, 32'd300, '0));
      plan.push_back(item_row(bfp_pkg::KIND_REQUEST, 32'd301, '0));
      plan.push_back(item_row(bfp_pkg::KIND_REQUEST, 32'hFFFF_FFFF, '0));
      plan.push_back(item_row(bfp_pkg::KIND_REQUEST, 32'd256, '1));
      plan.push_back(item_row(bfp_pkg::KIND_REQUEST, 32'd0, '0));
      plan.push_back(limit_row('0));
      plan.push_back(item_row(bfp_pkg::KIND_RELEASE, 32'd1000, 48'h5555_5555_5555));
      plan.push_back(limit_row(37'd2000));
      plan.push_back(item_row(bfp_pkg::KIND_RELEASE, 32'd1000, 48'h6666_6666_6666));
      plan.push_back(item_row(bfp_pkg::KIND_RELEASE, 32'd999, 48'hAAAA_AAAA_AAAA));
      plan.push_back(limit_row(BIG_LIMIT));
      plan.push_back(item_row(bfp_pkg::KIND_REQUEST, 32'd1000, '0));
      plan.push_back(item_row(bfp_pkg::KIND_REQUEST, 32'd600, '0));
      plan.push_back(limit_row(bfp_pkg::LIMIT_RESET));

      repeat (9) @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_limit)
            write_limit(plan[i].limit);
         else
            send_item(plan[i].kind, plan[i].block_size, plan[i].block_handle,
                      plan[i].typed, plan[i].outcome);
      end

      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 4)
            0: begin
               send_idle_pct = 11;
               recv_idle_pct = 69;
            end
            1: begin
               send_idle_pct = 69;
               recv_idle_pct = 11;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (seg % 4)
            0:       lim = BIG_LIMIT;
            1:       lim = bfp_pkg::TOTAL_W'({$urandom, $urandom});
            2:       lim = pool_sum + bfp_pkg::TOTAL_W'($urandom_range(300, 200000));
            default: lim = (seg == 3) ? '0 : bfp_pkg::LIMIT_RESET;
         endcase
         write_limit(lim);
         for (n = 0; n < SEG_ITEMS; n++) begin
            pick_item(n, kind, size, handle);
            send_item(kind, size, handle, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      if (mismatches == 0)
         $display("best_fit_free_block_pool_core_test: PASS");
      else
         $display("best_fit_free_block_pool_core_test: FAIL");
      $finish;
   end
endmodule
